// ===== design/stdc_pkg.sv =====
`timescale 1ns / 1ps

package stdc_pkg;

  localparam int unsigned MaxDigitsDefault = 4;

  localparam int unsigned ChW    = 8;
  localparam int unsigned ActW   = 3;
  localparam int unsigned MicroW = 3;
  localparam int unsigned StepW  = 14;

  // Character codes
  localparam logic [ChW-1:0] CH_NUL  = 8'h00;
  localparam logic [ChW-1:0] CH_M    = 8'h4D;
  localparam logic [ChW-1:0] CH_E    = 8'h45;
  localparam logic [ChW-1:0] CH_D    = 8'h44;
  localparam logic [ChW-1:0] CH_S    = 8'h53;
  localparam logic [ChW-1:0] CH_F    = 8'h46;
  localparam logic [ChW-1:0] CH_H    = 8'h48;
  localparam logic [ChW-1:0] CH_T    = 8'h54;
  localparam logic [ChW-1:0] CH_A    = 8'h41;
  localparam logic [ChW-1:0] CH_0    = 8'h30;
  localparam logic [ChW-1:0] CH_1    = 8'h31;
  localparam logic [ChW-1:0] CH_2    = 8'h32;
  localparam logic [ChW-1:0] CH_3    = 8'h33;
  localparam logic [ChW-1:0] CH_4    = 8'h34;
  localparam logic [ChW-1:0] CH_6    = 8'h36;
  localparam logic [ChW-1:0] CH_8    = 8'h38;
  localparam logic [ChW-1:0] CH_9    = 8'h39;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_ENABLE  = 3'd1,
    ACT_DISABLE = 3'd2,
    ACT_MICRO   = 3'd3,
    ACT_DIR     = 3'd4,
    ACT_STEPS   = 3'd5
  } action_e;

  typedef enum logic [MicroW-1:0] {
    MS_FULL    = 3'd0,
    MS_HALF    = 3'd1,
    MS_QUARTER = 3'd2,
    MS_EIGHTH  = 3'd3,
    MS_SIXTEEN = 3'd4,
    MS_THIRTY2 = 3'd5
  } micro_e;

  typedef enum logic [3:0] {
    P_START = 4'd0,
    P_M     = 4'd1,
    P_DEAD  = 4'd2,
    P_EN    = 4'd3,
    P_DIS   = 4'd4,
    P_MM    = 4'd5,
    P_MMS   = 4'd6,
    P_MMS0  = 4'd7,
    P_MMS1  = 4'd8,
    P_MMS3  = 4'd9,
    P_MICRO = 4'd10,
    P_MT    = 4'd11,
    P_DIR   = 4'd12,
    P_MS    = 4'd13
  } path_e;

  // Character handed from the input register to the decoder
  typedef struct packed {
    logic           en;
    logic [ChW-1:0] ch;
  } stdc_char_t;

  typedef struct packed {
    action_e           action;
    logic [MicroW-1:0] microstep;
    logic              direction;
    logic [StepW-1:0]  step_count;
  } stdc_result_t;

endpackage

// ===== design/stdc_if.sv =====
`timescale 1ns / 1ps

interface stdc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface stdc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  microstep;
  logic        direction;
  logic [13:0] step_count;

  modport source (output valid, output action, output microstep, output direction,
                  output step_count, input ready);
  modport sink   (input valid, input action, input microstep, input direction,
                  input step_count, output ready);
endinterface

// ===== design/stdc_decoder.sv =====
`timescale 1ns / 1ps

module stdc_decoder #(
  parameter int unsigned MAX_DIGITS = stdc_pkg::MaxDigitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stdc_pkg::stdc_char_t char_i,
  output stdc_pkg::stdc_result_t res_o
);
  import stdc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_DIGITS);

  path_e            path_q,  path_d;
  logic [StepW-1:0] value_q, value_d;
  logic [CntW-1:0]  cnt_q,   cnt_d;
  logic             ok_q,    ok_d;

  logic             is_digit;
  logic [StepW-1:0] digit;

  assign is_digit = (char_i.ch >= CH_0) && (char_i.ch <= CH_9);
  assign digit    = StepW'(char_i.ch - CH_0);

  always_comb begin
    path_d  = path_q;
    value_d = value_q;
    cnt_d   = cnt_q;
    ok_d    = ok_q;
    res_o   = '{action: ACT_NONE, microstep: '0, direction: 1'b0, step_count: '0};

    if (char_i.en && char_i.ch == CH_NUL) begin
      case (path_q)
        P_EN:    res_o.action = ACT_ENABLE;
        P_DIS:   res_o.action = ACT_DISABLE;
        P_MICRO: begin
          res_o.action    = ACT_MICRO;
          res_o.microstep = value_q[MicroW-1:0];
        end
        P_DIR: begin
          res_o.action    = ACT_DIR;
          res_o.direction = value_q[0];
        end
        P_MS: begin
          if (ok_q && cnt_q != '0) begin
            res_o.action     = ACT_STEPS;
            res_o.step_count = value_q;
          end
        end
        default: ;
      endcase
      // terminator returns the decoder to its start state
      path_d  = P_START;
      value_d = '0;
      cnt_d   = '0;
      ok_d    = 1'b1;
    end else if (char_i.en) begin
      case (path_q)
        P_START: path_d = (char_i.ch == CH_M) ? P_M : P_DEAD;
        P_M: begin
          case (char_i.ch)
            CH_E:    path_d = P_EN;
            CH_D:    path_d = P_DIS;
            CH_M:    path_d = P_MM;
            CH_T:    path_d = P_MT;
            CH_S:    path_d = P_MS;
            default: path_d = P_DEAD;
          endcase
        end
        P_MM: path_d = (char_i.ch == CH_S) ? P_MMS : P_DEAD;
        P_MMS: begin
          case (char_i.ch)
            CH_F: begin
              path_d  = P_MICRO;
              value_d = StepW'(MS_FULL);
            end
            CH_H: begin
              path_d  = P_MICRO;
              value_d = StepW'(MS_HALF);
            end
            CH_0:    path_d = P_MMS0;
            CH_1:    path_d = P_MMS1;
            CH_3:    path_d = P_MMS3;
            default: path_d = P_DEAD;
          endcase
        end
        P_MMS0: begin
          case (char_i.ch)
            CH_4: begin
              path_d  = P_MICRO;
              value_d = StepW'(MS_QUARTER);
            end
            CH_8: begin
              path_d  = P_MICRO;
              value_d = StepW'(MS_EIGHTH);
            end
            default: path_d = P_DEAD;
          endcase
        end
        P_MMS1: begin
          if (char_i.ch == CH_6) begin
            path_d  = P_MICRO;
            value_d = StepW'(MS_SIXTEEN);
          end else begin
            path_d = P_DEAD;
          end
        end
        P_MMS3: begin
          if (char_i.ch == CH_2) begin
            path_d  = P_MICRO;
            value_d = StepW'(MS_THIRTY2);
          end else begin
            path_d = P_DEAD;
          end
        end
        P_MT: begin
          case (char_i.ch)
            CH_H: begin
              path_d  = P_DIR;
              value_d = StepW'(1'b0);
            end
            CH_A: begin
              path_d  = P_DIR;
              value_d = StepW'(1'b1);
            end
            default: path_d = P_DEAD;
          endcase
        end
        P_MS: begin
          if (!is_digit) begin
            ok_d = 1'b0;
          end else if (cnt_q < CntMax) begin
            // value * 10 + digit, wrapping at the field width
            value_d = (value_q << 3) + (value_q << 1) + digit;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q  <= P_START;
      value_q <= '0;
      cnt_q   <= '0;
      ok_q    <= 1'b1;
    end else begin
      path_q  <= path_d;
      value_q <= value_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
    end
  end

endmodule

// ===== design/stepper_text_command_decoder_core.sv =====
`timescale 1ns / 1ps
// Path: a terminating zero byte passes through the input register, then the result
//   register, before its result shows; other characters give no result.
// Throughput: one character per cycle, set by the single-pass decode between the
//   input and result registers; stalls only while a result waits downstream.
// Reset: rst_ni asynchronous, active low; empties both registers and returns the
//   decoder to its start state at once.

module stepper_text_command_decoder_core #(
  parameter int unsigned MAX_DIGITS = stdc_pkg::MaxDigitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  stdc_char_if.sink     char_i,
  stdc_result_if.source result_o
);
  import stdc_pkg::*;

  // Input register
  logic           in_valid_q, in_valid_d;
  logic [ChW-1:0] in_ch_q;

  // Result register
  logic         out_valid_q, out_valid_d;
  stdc_result_t out_q;

  stdc_char_t   dec_char;
  stdc_result_t dec_res;

  logic is_term;
  logic out_free;
  logic proc;
  logic in_take;

  assign is_term  = (in_ch_q == CH_NUL);
  assign out_free = !out_valid_q || result_o.ready;
  // Plain characters never stall; a terminator waits for a free result slot.
  assign proc     = in_valid_q && (!is_term || out_free);

  assign char_i.ready = !in_valid_q || proc;
  assign in_take      = char_i.valid && char_i.ready;
  assign in_valid_d   = in_take || (in_valid_q && !proc);

  assign dec_char = '{en: proc, ch: in_ch_q};

  stdc_decoder #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_decoder (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(dec_char),
    .res_o (dec_res)
  );

  always_comb begin
    if (out_free) begin
      out_valid_d = proc && is_term;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q <= char_i.ch;
    end
    if (proc && is_term) begin
      out_q <= dec_res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.action     = out_q.action;
  assign result_o.microstep  = out_q.microstep;
  assign result_o.direction  = out_q.direction;
  assign result_o.step_count = out_q.step_count;

endmodule

// ===== design/stdc_checker.sv =====
`timescale 1ns / 1ps

module stdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  action_i,
  input logic [2:0]  microstep_i,
  input logic        direction_i,
  input logic [13:0] step_count_i
);
  import stdc_pkg::*;

  // stalled request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i)
      && $stable(microstep_i) && $stable(direction_i) && $stable(step_count_i))
    else $error("result changed while stalled");

  a_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> action_i <= ACT_STEPS
      && (action_i == ACT_MICRO || microstep_i == '0)
      && (action_i == ACT_DIR || direction_i == 1'b0))
    else $error("side fields set for wrong action");

  a_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> step_count_i <= 14'd9999
      && (action_i == ACT_STEPS || step_count_i == '0))
    else $error("bad step count");

  a_micro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == ACT_MICRO |-> microstep_i <= MS_THIRTY2)
    else $error("bad microstep code");

  a_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind stepper_text_command_decoder_core stdc_checker u_stdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .action_i    (result_o.action),
  .microstep_i (result_o.microstep),
  .direction_i (result_o.direction),
  .step_count_i(result_o.step_count)
);

// ===== tb/stdc_decode_monitor.sv =====
`timescale 1ns / 1ps

module stdc_decode_monitor #(
  parameter int unsigned MaxDigits = stdc_pkg::MaxDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stdc_char_if        chars,
  stdc_result_if      results,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import stdc_pkg::*;

  localparam logic DirRight = 1'b0;
  localparam logic DirLeft  = 1'b1;

  typedef struct packed {
    path_e            path;
    logic [StepW-1:0] value;
    logic [2:0]       count;
    logic             digits_ok;
  } decode_state_t;

  localparam decode_state_t IdleState = '{
    path: P_START, value: '0, count: '0, digits_ok: 1'b1
  };

  decode_state_t cmd_state;
  stdc_result_t  expected_actions[$];

  function automatic decode_state_t advance_decode(decode_state_t s, logic [ChW-1:0] c);
    decode_state_t n;
    n = s;
    case (s.path)
      P_START: n.path = (c == CH_M) ? P_M : P_DEAD;
      P_M: begin
        if (c == CH_E)      n.path = P_EN;
        else if (c == CH_D) n.path = P_DIS;
        else if (c == CH_M) n.path = P_MM;
        else if (c == CH_T) n.path = P_MT;
        else if (c == CH_S) n.path = P_MS;
        else                n.path = P_DEAD;
      end
      P_MM: n.path = (c == CH_S) ? P_MMS : P_DEAD;
      P_MMS: begin
        if (c == CH_F) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_FULL);
        end else if (c == CH_H) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_HALF);
        end else if (c == CH_0) begin
          n.path = P_MMS0;
        end else if (c == CH_1) begin
          n.path = P_MMS1;
        end else if (c == CH_3) begin
          n.path = P_MMS3;
        end else begin
          n.path = P_DEAD;
        end
      end
      P_MMS0: begin
        if (c == CH_4) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_QUARTER);
        end else if (c == CH_8) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_EIGHTH);
        end else begin
          n.path = P_DEAD;
        end
      end
      P_MMS1: begin
        if (c == CH_6) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_SIXTEEN);
        end else begin
          n.path = P_DEAD;
        end
      end
      P_MMS3: begin
        if (c == CH_2) begin
          n.path  = P_MICRO;
          n.value = StepW'(MS_THIRTY2);
        end else begin
          n.path = P_DEAD;
        end
      end
      P_MT: begin
        if (c == CH_H) begin
          n.path  = P_DIR;
          n.value = StepW'(DirRight);
        end else if (c == CH_A) begin
          n.path  = P_DIR;
          n.value = StepW'(DirLeft);
        end else begin
          n.path = P_DEAD;
        end
      end
      P_MS: begin
        if (c < CH_0 || c > CH_9) begin
          n.digits_ok = 1'b0;
        end else if (s.count < MaxDigits) begin
          // digits past the limit are only checked, not added
          n.value = StepW'(s.value * 10 + (c - CH_0));
          n.count = s.count + 3'd1;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic stdc_result_t decoded_action(decode_state_t s);
    stdc_result_t r;
    r = '0;
    r.action = ACT_NONE;
    case (s.path)
      P_EN:  r.action = ACT_ENABLE;
      P_DIS: r.action = ACT_DISABLE;
      P_MICRO: begin
        r.action    = ACT_MICRO;
        r.microstep = s.value[MicroW-1:0];
      end
      P_DIR: begin
        r.action    = ACT_DIR;
        r.direction = s.value[0];
      end
      P_MS: begin
        if (s.digits_ok && s.count != 0) begin
          r.action     = ACT_STEPS;
          r.step_count = s.value;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count_o++;
    $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stdc_result_t want;
    if (!rst_ni) begin
      cmd_state <= IdleState;
      expected_actions.delete();
      pending_o <= 0;
      mismatch_count_o = 0;
    end else begin
      // results first: one taken this cycle cannot belong to a terminator taken now
      if (results.valid && results.ready) begin
        if (expected_actions.size() == 0) begin
          report_mismatch($sformatf("unexpected result, action %0d", results.action));
        end else begin
          want = expected_actions.pop_front();
          if (results.action !== want.action)
            report_mismatch($sformatf("action %0d, wanted %0d",
                                      results.action, want.action));
          if (results.microstep !== want.microstep)
            report_mismatch($sformatf("microstep %0d, wanted %0d",
                                      results.microstep, want.microstep));
          if (results.direction !== want.direction)
            report_mismatch($sformatf("direction %0d, wanted %0d",
                                      results.direction, want.direction));
          if (results.step_count !== want.step_count)
            report_mismatch($sformatf("step_count %0d, wanted %0d",
                                      results.step_count, want.step_count));
        end
      end
      if (chars.valid && chars.ready) begin
        if (chars.ch == CH_NUL) begin
          expected_actions.push_back(decoded_action(cmd_state));
          cmd_state <= IdleState;
        end else begin
          cmd_state <= advance_decode(cmd_state, chars.ch);
        end
      end
      pending_o <= expected_actions.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the stepper command decoder. The monitor beside the
// block does all prediction and comparison; this module only feeds characters,
// throttles the result side and decides pass or fail at the end.
module tb;
  import stdc_pkg::*;

  localparam int unsigned MaxDigits     = MaxDigitsDefault;
  // cycles with no request taken on either side before the run is abandoned
  localparam int unsigned WatchdogLimit = 5000;
  // characters per random phase, about 1160 in total
  localparam int unsigned PhaseChars    = 290;
  // results pass through the input and result registers; allow a margin
  localparam int unsigned DrainCycles   = 8;

  logic clk_i;
  logic rst_ni;

  stdc_char_if   char_if ();
  stdc_result_if result_if ();

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_pct;       // sender: chance per cycle of holding back
  int unsigned stall_pct;      // receiver: chance per cycle of dropping ready
  int unsigned chars_sent;
  int unsigned quiet_cycles;

  logic [ChW-1:0] cmd_text[$];

  stepper_text_command_decoder_core #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .result_o(result_if)
  );

  stdc_decode_monitor #(
    .MaxDigits(MaxDigits)
  ) u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .chars           (char_if),
    .results         (result_if),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Receiver back-pressure: a fresh coin each cycle, weighted by stall_pct.
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any request taken on either channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((char_if.valid && char_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One character request. Idle cycles are inserted ahead of it so gaps land
  // between any two characters, terminators included. valid stays high from
  // one request to the next when no gap is drawn.
  task automatic send_char(input logic [ChW-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.ch    <= c;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) cmd_text.push_back(s[i]);
  endtask

  // Sends the buffered command followed by its zero terminator.
  task automatic send_command();
    foreach (cmd_text[i]) send_char(cmd_text[i]);
    send_char(CH_NUL);
    cmd_text.delete();
  endtask

  function automatic logic [ChW-1:0] any_char();
    return ChW'($urandom_range(255, 1));
  endfunction

  function automatic logic [ChW-1:0] digit_char();
    return CH_0 + ChW'($urandom_range(9));
  endfunction

  // Favours the neighbours of the digit range, which are the likeliest to slip through.
  function automatic logic [ChW-1:0] non_digit_char();
    logic [ChW-1:0] c;
    case ($urandom_range(3))
      0:       c = CH_0 - 8'd1;
      1:       c = CH_9 + 8'd1;
      default: begin
        c = any_char();
        while (c >= CH_0 && c <= CH_9) c = any_char();
      end
    endcase
    return c;
  endfunction

  // Nonzero characters after a finished prefix; they must not alter the action.
  task automatic add_trailing_junk();
    int n;
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(5, 1);
      repeat (n) cmd_text.push_back(any_char());
    end
  endtask

  function automatic string prefix_text(input int unsigned idx);
    case (idx)
      0:       return "ME";
      1:       return "MD";
      2:       return "MMSF";
      3:       return "MMSH";
      4:       return "MMS04";
      5:       return "MMS08";
      6:       return "MMS16";
      7:       return "MMS32";
      8:       return "MTH";
      default: return "MTA";
    endcase
  endfunction

  // Mostly well-formed commands with random content; the rest are damaged
  // prefixes and plain noise.
  task automatic build_random_command();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 10) begin
      add_text(prefix_text($urandom_range(1)));
      add_trailing_junk();
    end else if (kind < 25) begin
      add_text(prefix_text($urandom_range(7, 2)));
      add_trailing_junk();
    end else if (kind < 35) begin
      add_text(prefix_text($urandom_range(9, 8)));
      add_trailing_junk();
    end else if (kind < 65) begin
      // step count: usually 1..4 digits, now and then none or too many
      add_text("MS");
      n = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
      repeat (n) cmd_text.push_back(digit_char());
      if ($urandom_range(5) == 0)
        cmd_text.insert($urandom_range(cmd_text.size(), 2), non_digit_char());
    end else if (kind < 82) begin
      // damaged prefix: cut short or one character replaced
      add_text(prefix_text($urandom_range(9)));
      if ($urandom_range(1) == 0) begin
        n = $urandom_range(cmd_text.size() - 1);
        while (cmd_text.size() > n) void'(cmd_text.pop_back());
      end else begin
        cmd_text[$urandom_range(cmd_text.size() - 1)] = any_char();
      end
    end else begin
      n = $urandom_range(8);
      if ($urandom_range(1) == 0) cmd_text.push_back(CH_M);
      repeat (n) cmd_text.push_back(any_char());
    end
  endtask

  // Directed opening: every command, the step count extremes, surplus and
  // missing digits, a bad digit either side of the range, the two dead
  // two-letter commands, an empty command, an early terminator, trailing
  // characters after a finished prefix and bytes with the top bit set.
  string directed_cmds[] = '{
    "ME", "MD", "MMSF", "MMSH", "MMS04", "MMS08", "MMS16", "MMS32", "MTH", "MTA",
    "MS0", "MS9999", "MS123456", "MS", "MS12X", "MS/", "MS:", "MA", "MF", "",
    "M", "MMS05", "MEzz\377", "\200\377\177"
  };

  initial begin
    rst_ni          = 1'b0;
    char_if.valid   = 1'b0;
    char_if.ch      = '0;
    result_if.ready = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    chars_sent      = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cmds[i]) begin
      add_text(directed_cmds[i]);
      send_command();
    end

    // Random phases: free running, sender sparse, receiver stalling, both light.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 70;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 70;
        end
        default: begin
          idle_pct = 10;
          stall_pct <= 10;
        end
      endcase
      while (chars_sent < (phase + 1) * PhaseChars) begin
        build_random_command();
        send_command();
      end
    end

    char_if.valid <= 1'b0;
    stall_pct <= 0;

    // Wait out the outstanding results; the watchdog bounds this.
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/stdc_pkg.sv
design/stdc_if.sv
design/stdc_decoder.sv
design/stepper_text_command_decoder_core.sv
design/stdc_checker.sv
tb/stdc_decode_monitor.sv
tb/tb.sv
